// ----- design/page_framebuffer_sprite_blitter_core_defines.svh -----
// Assertion macros shared by the blitter modules.
// Each check is compiled out when SYNTHESIS is defined.
`ifndef PAGE_FRAMEBUFFER_SPRITE_BLITTER_CORE_DEFINES_SVH
`define PAGE_FRAMEBUFFER_SPRITE_BLITTER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// property must hold at every clock edge out of reset
`define PFSB_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// condition must never be seen out of reset
`define PFSB_ASSERT_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define PFSB_ASSERT(lbl, clk, rst, prop, msg)
`define PFSB_ASSERT_NEVER(lbl, clk, rst, cond, msg)
`endif

`endif

// ----- design/pfsb_pkg.sv -----
`timescale 1ns / 1ps

package pfsb_pkg;

   // default sizes of the stores
   localparam int NUM_IMAGES_DEF  = 4;
   localparam int PAGES_DEF       = 8;
   localparam int COLUMNS_DEF     = 128;
   localparam int IMAGE_BYTES_DEF = 1024;

   // field widths of the words on the ports
   localparam int FUNC_W     = 2;
   localparam int SEL_W      = 2;
   localparam int IDX_W      = 10;
   localparam int FPAGE_W    = 3;
   localparam int FCOL_W     = 7;
   localparam int DATA_W     = 8;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 8;

   // register reset values
   localparam logic [7:0] IMG_WIDTH_RST  = 8'd128;
   localparam logic [3:0] IMG_HEIGHT_RST = 4'd8;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_LOAD  = 2'd0,
      FUNC_BLIT  = 2'd1,
      FUNC_READ  = 2'd2,
      FUNC_CLEAR = 2'd3
   } func_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BLIT_MODE   = 3'd0,
      CSR_IMG_WIDTH   = 3'd1,
      CSR_IMG_HEIGHT  = 3'd2,
      CSR_POS_X       = 3'd3,
      CSR_POS_PAGE    = 3'd4,
      CSR_POS_BIT_Y   = 3'd5
   } csr_index_type;

   // controller to datapath
   typedef struct packed {
      logic accept;      // word taken from the request channel
      logic clr_step;    // write one zero byte of the frame sweep
      logic prep_start;  // latch blit bounds from the registers
      logic red_step;    // one subtract step of the modulo reducer
      logic latch_wmod;  // width reduced, start on the column offset
      logic latch_col;   // column offset reduced, set up the walk
      logic k_adv;       // step the image row bases by one page
      logic blit_rd;     // read the image bytes for this frame byte
      logic blit_wr;     // write the frame byte and move on
      logic rsp_load;    // load the response register
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic clr_last;
      logic red_done;
      logic kprep_done;
      logic blit_last;
      logic blit_skip;
   } dp_status_type;

endpackage

// ----- design/pfsb_ram.sv -----
`timescale 1ns / 1ps

module pfsb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/pfsb_dpath.sv -----
`timescale 1ns / 1ps
`include "page_framebuffer_sprite_blitter_core_defines.svh"

module pfsb_dpath #(
   parameter int NUM_IMAGES  = pfsb_pkg::NUM_IMAGES_DEF,
   parameter int PAGES       = pfsb_pkg::PAGES_DEF,
   parameter int COLUMNS     = pfsb_pkg::COLUMNS_DEF,
   parameter int IMAGE_BYTES = pfsb_pkg::IMAGE_BYTES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  pfsb_pkg::ctrl_cmd_type          cmd,
   output pfsb_pkg::dp_status_type         status,
   input  logic [pfsb_pkg::FUNC_W-1:0]     req_func,
   input  logic [pfsb_pkg::SEL_W-1:0]      req_image_select,
   input  logic [pfsb_pkg::IDX_W-1:0]      req_image_index,
   input  logic [pfsb_pkg::FPAGE_W-1:0]    req_frame_page,
   input  logic [pfsb_pkg::FCOL_W-1:0]     req_frame_column,
   input  logic [pfsb_pkg::DATA_W-1:0]     req_data_byte,
   input  logic                            csr_write,
   input  logic [pfsb_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [pfsb_pkg::CSR_DATA_W-1:0] csr_data,
   output logic [pfsb_pkg::DATA_W-1:0]     rsp_read_data
);

   import pfsb_pkg::*;

   localparam int IAW      = $clog2(IMAGE_BYTES);
   localparam int IMG_DEPTH = NUM_IMAGES * IMAGE_BYTES;
   localparam int IMAW     = $clog2(IMG_DEPTH);
   localparam int FR_DEPTH = PAGES * COLUMNS;
   localparam int FAW      = $clog2(FR_DEPTH);
   localparam int YW       = (PAGES > 1) ? $clog2(PAGES) : 1;
   localparam int XW       = $clog2(COLUMNS);

   localparam logic signed [10:0] P_LAST = 11'(PAGES - 1);
   localparam logic signed [10:0] C_LAST = 11'(COLUMNS - 1);
   localparam logic signed [10:0] C_NUM  = 11'(COLUMNS);

   // configuration registers
   logic       blit_mode_ff;
   logic [7:0] img_width_ff;
   logic [3:0] img_height_ff;
   logic [7:0] pos_x_ff;
   logic [3:0] pos_page_ff;
   logic [6:0] pos_bit_y_ff;

   // latched item
   func_type        func_ff;
   logic [SEL_W-1:0] sel_ff;
   logic            rd_ok_ff;

   // blit walk state
   logic [YW-1:0]  ys_ff, ye_ff, y_ff;
   logic [XW-1:0]  xs_ff, xl_ff, x_ff;
   logic [4:0]     k0_ff, k_ff, kcnt_ff;
   logic [3:0]     h_ff;
   logic [2:0]     s_ff;
   logic           skip_ff;
   logic [7:0]     c0_ff;
   logic [7:0]     red_ff;
   logic [IAW-1:0] w_mod_ff, c0_mod_ff, col_mod_ff;
   logic [IAW-1:0] cur_base_ff, prev_base_ff;

   logic [FAW-1:0] clr_cnt_ff;
   logic [DATA_W-1:0] rsp_data_ff;

   // bounds worked out from the registers
   logic signed [10:0] w_s, h_s, px_s, pp_s, b_s;
   logic signed [10:0] ys_c, ye_c, xs_c, xl_c, k0_c, c0_c;
   logic               empty_c;

   always_comb begin
      w_s  = $signed({3'b000, img_width_ff});
      h_s  = $signed({7'b0000000, img_height_ff});
      px_s = $signed({3'b000, pos_x_ff});
      pp_s = $signed({7'b0000000, pos_page_ff});
      b_s  = $signed({7'b0000000, pos_bit_y_ff[6:3]});
      if (blit_mode_ff) begin
         // right edge exclusive at pos_x, bottom page from pos_bit_y
         ys_c    = (b_s > h_s) ? (b_s - h_s) : 11'sd0;
         ye_c    = (b_s > P_LAST) ? P_LAST : b_s;
         xs_c    = (px_s > w_s) ? (px_s - w_s) : 11'sd0;
         xl_c    = ((px_s > C_NUM) ? C_NUM : px_s) - 11'sd1;
         k0_c    = ys_c - b_s + h_s;
         c0_c    = xs_c + w_s - px_s;
         empty_c = (ys_c > ye_c) || (xs_c > xl_c);
      end else begin
         // top-left at pos_x, pos_page
         ys_c    = pp_s;
         ye_c    = ((pp_s + h_s - 11'sd1) > P_LAST) ? P_LAST : (pp_s + h_s - 11'sd1);
         xs_c    = px_s;
         xl_c    = ((px_s + w_s - 11'sd1) > C_LAST) ? C_LAST : (px_s + w_s - 11'sd1);
         k0_c    = 11'sd0;
         c0_c    = 11'sd0;
         empty_c = (ye_c < ys_c) || (xl_c < xs_c);
      end
   end

   // modulo adds on image byte offsets
   logic [IAW:0]   bsum, lo_sum, hi_sum;
   logic [IAW-1:0] base_next, lo_idx, hi_idx, col_next;

   always_comb begin
      bsum      = {1'b0, cur_base_ff} + {1'b0, w_mod_ff};
      base_next = (bsum >= (IAW+1)'(IMAGE_BYTES)) ?
                  IAW'(bsum - (IAW+1)'(IMAGE_BYTES)) : IAW'(bsum);
      lo_sum    = {1'b0, cur_base_ff} + {1'b0, col_mod_ff};
      lo_idx    = (lo_sum >= (IAW+1)'(IMAGE_BYTES)) ?
                  IAW'(lo_sum - (IAW+1)'(IMAGE_BYTES)) : IAW'(lo_sum);
      hi_sum    = {1'b0, prev_base_ff} + {1'b0, col_mod_ff};
      hi_idx    = (hi_sum >= (IAW+1)'(IMAGE_BYTES)) ?
                  IAW'(hi_sum - (IAW+1)'(IMAGE_BYTES)) : IAW'(hi_sum);
      col_next  = (col_mod_ff == IAW'(IMAGE_BYTES - 1)) ? '0 : col_mod_ff + 1'b1;
   end

   // image store: two copies written alike, one read port each
   logic [IMAW-1:0] img_base, load_addr, lo_addr, hi_addr;
   logic            load_en;
   logic [7:0]      rd_lo, rd_hi;

   assign img_base  = IMAW'(IMAW'(sel_ff) * IMAW'(IMAGE_BYTES));
   assign lo_addr   = img_base + IMAW'(lo_idx);
   assign hi_addr   = img_base + IMAW'(hi_idx);
   assign load_addr = IMAW'(IMAW'(req_image_select) * IMAW'(IMAGE_BYTES))
                      + IMAW'(req_image_index);
   assign load_en   = cmd.accept && (req_func == FUNC_LOAD)
                      && (req_image_select < NUM_IMAGES) && (req_image_index < IMAGE_BYTES);

   pfsb_ram #(.WIDTH(8), .DEPTH(IMG_DEPTH)) u_img_lo (
      .clock   (clock),
      .wr_en   (load_en),
      .wr_addr (load_addr),
      .wr_data (req_data_byte),
      .rd_en   (cmd.blit_rd),
      .rd_addr (lo_addr),
      .rd_data (rd_lo)
   );

   pfsb_ram #(.WIDTH(8), .DEPTH(IMG_DEPTH)) u_img_hi (
      .clock   (clock),
      .wr_en   (load_en),
      .wr_addr (load_addr),
      .wr_data (req_data_byte),
      .rd_en   (cmd.blit_rd),
      .rd_addr (hi_addr),
      .rd_data (rd_hi)
   );

   // merge the image rows into one frame byte
   logic [7:0] lo_sh, hi_sh, blit_byte;
   logic       k_zero, k_below;

   always_comb begin
      k_zero  = (k_ff == 5'd0);
      k_below = (k_ff < {1'b0, h_ff});
      lo_sh   = (k_below || k_zero) ? (rd_lo << s_ff) : 8'd0;
      hi_sh   = (!k_zero && (s_ff != 3'd0)) ? (rd_hi >> (4'd8 - {1'b0, s_ff})) : 8'd0;
      if (k_zero) begin
         blit_byte = lo_sh;
      end else if (k_below) begin
         blit_byte = lo_sh | hi_sh;
      end else begin
         blit_byte = hi_sh;
      end
   end

   // frame store: sweep clear or blit on the write side
   logic           fr_wr_en;
   logic [FAW-1:0] fr_wr_addr, fr_rd_addr;
   logic [7:0]     fr_wr_data, fr_rdata;

   assign fr_wr_en   = cmd.clr_step || cmd.blit_wr;
   assign fr_wr_addr = cmd.clr_step ? clr_cnt_ff : FAW'(y_ff * COLUMNS + x_ff);
   assign fr_wr_data = cmd.clr_step ? 8'd0 : blit_byte;
   assign fr_rd_addr = FAW'(req_frame_page * COLUMNS + req_frame_column);

   pfsb_ram #(.WIDTH(8), .DEPTH(FR_DEPTH)) u_frame (
      .clock   (clock),
      .wr_en   (fr_wr_en),
      .wr_addr (fr_wr_addr),
      .wr_data (fr_wr_data),
      .rd_en   (cmd.accept),
      .rd_addr (fr_rd_addr),
      .rd_data (fr_rdata)
   );

   // configuration writes and clear sweep counter
   always_ff @(posedge clock) begin
      if (reset) begin
         blit_mode_ff  <= 1'b0;
         img_width_ff  <= IMG_WIDTH_RST;
         img_height_ff <= IMG_HEIGHT_RST;
         pos_x_ff      <= '0;
         pos_page_ff   <= '0;
         pos_bit_y_ff  <= '0;
         clr_cnt_ff    <= '0;
      end else begin
         if (csr_write) begin
            unique case (csr_index)
               CSR_BLIT_MODE:  blit_mode_ff  <= csr_data[0];
               CSR_IMG_WIDTH:  img_width_ff  <= csr_data;
               CSR_IMG_HEIGHT: img_height_ff <= csr_data[3:0];
               CSR_POS_X:      pos_x_ff      <= csr_data;
               CSR_POS_PAGE:   pos_page_ff   <= csr_data[3:0];
               CSR_POS_BIT_Y:  pos_bit_y_ff  <= csr_data[6:0];
               default: ;
            endcase
         end
         if (cmd.accept) begin
            clr_cnt_ff <= '0;
         end else if (cmd.clr_step) begin
            clr_cnt_ff <= status.clr_last ? '0 : clr_cnt_ff + 1'b1;
         end
      end
   end

   // item latch, blit walk and response
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         func_ff  <= func_type'(req_func);
         sel_ff   <= req_image_select;
         rd_ok_ff <= (req_frame_page < PAGES) && (req_frame_column < COLUMNS);
      end
      if (cmd.prep_start) begin
         ys_ff        <= YW'(ys_c);
         ye_ff        <= YW'(ye_c);
         xs_ff        <= XW'(xs_c);
         xl_ff        <= XW'(xl_c);
         k0_ff        <= 5'(k0_c);
         c0_ff        <= 8'(c0_c);
         h_ff         <= img_height_ff;
         s_ff         <= blit_mode_ff ? pos_bit_y_ff[2:0] : 3'd0;
         skip_ff      <= empty_c || (sel_ff >= NUM_IMAGES);
         red_ff       <= img_width_ff;
         kcnt_ff      <= '0;
         cur_base_ff  <= '0;
         prev_base_ff <= '0;
      end
      if (cmd.red_step && (red_ff >= IMAGE_BYTES)) begin
         red_ff <= red_ff - 8'(IMAGE_BYTES);
      end
      if (cmd.latch_wmod) begin
         w_mod_ff <= IAW'(red_ff);
         red_ff   <= c0_ff;
      end
      if (cmd.latch_col) begin
         c0_mod_ff  <= IAW'(red_ff);
         col_mod_ff <= IAW'(red_ff);
         x_ff       <= xs_ff;
         y_ff       <= ys_ff;
         k_ff       <= k0_ff;
      end
      if (cmd.k_adv) begin
         prev_base_ff <= cur_base_ff;
         cur_base_ff  <= base_next;
         kcnt_ff      <= kcnt_ff + 1'b1;
      end
      if (cmd.blit_wr) begin
         if (x_ff == xl_ff) begin
            if (y_ff != ye_ff) begin
               // next page: rewind the column, step the row bases
               y_ff         <= y_ff + 1'b1;
               k_ff         <= k_ff + 1'b1;
               x_ff         <= xs_ff;
               col_mod_ff   <= c0_mod_ff;
               prev_base_ff <= cur_base_ff;
               cur_base_ff  <= base_next;
            end
         end else begin
            x_ff       <= x_ff + 1'b1;
            col_mod_ff <= col_next;
         end
      end
      if (cmd.rsp_load) begin
         rsp_data_ff <= ((func_ff == FUNC_READ) && rd_ok_ff) ? fr_rdata : 8'd0;
      end
   end

   assign status.clr_last   = (clr_cnt_ff == FAW'(FR_DEPTH - 1));
   assign status.red_done   = (red_ff < IMAGE_BYTES);
   assign status.kprep_done = (kcnt_ff == k0_ff);
   assign status.blit_last  = (x_ff == xl_ff) && (y_ff == ye_ff);
   assign status.blit_skip  = skip_ff;
   assign rsp_read_data     = rsp_data_ff;

   `PFSB_ASSERT(a_blit_in_frame, clock, reset, cmd.blit_wr |-> (y_ff < PAGES) && (x_ff < COLUMNS), "blit write outside the frame")
   `PFSB_ASSERT(a_idx_reduced, clock, reset, cmd.blit_rd |-> (col_mod_ff < IMAGE_BYTES) && (cur_base_ff < IMAGE_BYTES) && (prev_base_ff < IMAGE_BYTES), "image offset not reduced")
   `PFSB_ASSERT_NEVER(a_wr_clash, clock, reset, cmd.clr_step && cmd.blit_wr, "clear and blit write together")

endmodule

// ----- design/pfsb_ctrl.sv -----
`timescale 1ns / 1ps
`include "page_framebuffer_sprite_blitter_core_defines.svh"

module pfsb_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [pfsb_pkg::FUNC_W-1:0] req_func,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output pfsb_pkg::ctrl_cmd_type      cmd,
   input  pfsb_pkg::dp_status_type     status
);

   import pfsb_pkg::*;

   typedef enum logic [3:0] {
      S_INIT,
      S_IDLE,
      S_CLEAR,
      S_PREP_START,
      S_PREP_W,
      S_PREP_C,
      S_PREP_K,
      S_BLIT_RD,
      S_BLIT_WR,
      S_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_INIT: begin
            cmd.clr_step = 1'b1;
            if (status.clr_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
            if (req_valid) begin
               case (req_func)
                  FUNC_BLIT:  state_in = S_PREP_START;
                  FUNC_CLEAR: state_in = S_CLEAR;
                  default:    state_in = S_FINISH;
               endcase
            end
         end
         S_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (status.clr_last) begin
               state_in = S_FINISH;
            end
         end
         S_PREP_START: begin
            cmd.prep_start = 1'b1;
            state_in       = S_PREP_W;
         end
         S_PREP_W: begin
            if (status.blit_skip) begin
               state_in = S_FINISH;
            end else if (status.red_done) begin
               cmd.latch_wmod = 1'b1;
               state_in       = S_PREP_C;
            end else begin
               cmd.red_step = 1'b1;
            end
         end
         S_PREP_C: begin
            if (status.red_done) begin
               cmd.latch_col = 1'b1;
               state_in      = S_PREP_K;
            end else begin
               cmd.red_step = 1'b1;
            end
         end
         S_PREP_K: begin
            if (status.kprep_done) begin
               state_in = S_BLIT_RD;
            end else begin
               cmd.k_adv = 1'b1;
            end
         end
         S_BLIT_RD: begin
            cmd.blit_rd = 1'b1;
            state_in    = S_BLIT_WR;
         end
         S_BLIT_WR: begin
            cmd.blit_wr = 1'b1;
            state_in    = status.blit_last ? S_FINISH : S_BLIT_RD;
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_INIT;
      endcase
   end

   // response slot
   always_comb begin
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `PFSB_ASSERT(a_one_item, clock, reset, (req_valid && req_ready) |=> !req_ready, "second word taken while busy")
   `PFSB_ASSERT(a_rsp_shown, clock, reset, cmd.rsp_load |=> rsp_valid_ff, "loaded response not shown")
   `PFSB_ASSERT(a_init_quiet, clock, reset, (state_ff == S_INIT) |-> (!req_ready && !rsp_valid_ff), "activity during the clearing pass")

endmodule

// ----- design/page_framebuffer_sprite_blitter_core.sv -----
`timescale 1ns / 1ps
// Sprite blitter over a page-organised framebuffer (PAGES x COLUMNS bytes).
// Request channel (req_*): one word per operation: load an image byte, blit
// a stored image, read a frame byte, or clear the frame. Every word gives
// exactly one response word (rsp_read_data: frame byte for a read, else 0).
// Configuration (csr_*): register writes, always ready; write only while idle.
// Sequence, from the accepted word to the loading of the response:
//   load, read: S_IDLE accepts, S_FINISH loads the response (read data from
//     the frame RAM's registered port). clear: S_CLEAR zeroes one frame byte per cycle.
//   blit: S_PREP_START, S_PREP_W, S_PREP_C, then S_PREP_K steps the row bases to
//     image row k0, the clipped top image row; each frame byte then needs an image
//     RAM read (S_BLIT_RD) then a frame write (S_BLIT_WR). A blit that writes nothing
//     goes from S_PREP_W straight to S_FINISH. Width and column offset are reduced
//     modulo IMAGE_BYTES by a subtract loop, which takes steps only when IMAGE_BYTES is below 256.
// Only one operation is in progress at a time; the next word is taken the
// cycle after the response is loaded, at the earliest.
// Reset (synchronous): registers go to their defaults and a clearing pass
// zeroes all PAGES*COLUMNS bytes of the frame store (1024 by default); no
// request is taken until it ends, configuration writes are taken throughout.
// Stall: the response waits in its register; the next request is still taken,
// and a finished operation holds until the register is free.
module page_framebuffer_sprite_blitter_core #(
   parameter int NUM_IMAGES  = pfsb_pkg::NUM_IMAGES_DEF,
   parameter int PAGES       = pfsb_pkg::PAGES_DEF,
   parameter int COLUMNS     = pfsb_pkg::COLUMNS_DEF,
   parameter int IMAGE_BYTES = pfsb_pkg::IMAGE_BYTES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [pfsb_pkg::FUNC_W-1:0]     req_func,
   input  logic [pfsb_pkg::SEL_W-1:0]      req_image_select,
   input  logic [pfsb_pkg::IDX_W-1:0]      req_image_index,
   input  logic [pfsb_pkg::FPAGE_W-1:0]    req_frame_page,
   input  logic [pfsb_pkg::FCOL_W-1:0]     req_frame_column,
   input  logic [pfsb_pkg::DATA_W-1:0]     req_data_byte,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [pfsb_pkg::DATA_W-1:0]     rsp_read_data,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [pfsb_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [pfsb_pkg::CSR_DATA_W-1:0] csr_data
);

   import pfsb_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   // registers take a write every cycle
   assign csr_ready = 1'b1;

   pfsb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_func  (req_func),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .status    (status)
   );

   pfsb_dpath #(
      .NUM_IMAGES  (NUM_IMAGES),
      .PAGES       (PAGES),
      .COLUMNS     (COLUMNS),
      .IMAGE_BYTES (IMAGE_BYTES)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_func         (req_func),
      .req_image_select (req_image_select),
      .req_image_index  (req_image_index),
      .req_frame_page   (req_frame_page),
      .req_frame_column (req_frame_column),
      .req_data_byte    (req_data_byte),
      .csr_write        (csr_valid && csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .rsp_read_data    (rsp_read_data)
   );

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
   import pfsb_pkg::*;

   localparam int COLS        = COLUMNS_DEF;
   localparam int PAGES       = PAGES_DEF;
   localparam int IMG_BYTES   = IMAGE_BYTES_DEF;
   localparam int TOTAL_WORDS = 770;
   localparam int STALL_LIMIT = 20000;

   // Mirror of the framebuffer, the image stores and the registers; every
   // accepted request word queues the read_data byte it must produce.
   class frame_shadow;
      bit [7:0] image_mem [0:NUM_IMAGES_DEF*IMG_BYTES-1];
      bit [7:0] frame_mem [0:PAGES*COLS-1];
      bit       scroll_mode;
      bit [7:0] width;
      bit [3:0] height;
      bit [7:0] pos_x;
      bit [3:0] pos_page;
      bit [6:0] pos_bit_y;
      bit [7:0] bytes_due [$];
      int       errors;
      int       compared;

      function new();
         width  = IMG_WIDTH_RST;
         height = IMG_HEIGHT_RST;
      endfunction

      function void set_reg(csr_index_type r, bit [7:0] d);
         case (r)
            CSR_BLIT_MODE:  scroll_mode = d[0];
            CSR_IMG_WIDTH:  width       = d;
            CSR_IMG_HEIGHT: height      = d[3:0];
            CSR_POS_X:      pos_x       = d;
            CSR_POS_PAGE:   pos_page    = d[3:0];
            CSR_POS_BIT_Y:  pos_bit_y   = d[6:0];
            default: ;
         endcase
      endfunction

      // byte offsets past the end of an image wrap round
      function bit [7:0] image_byte(int sel, int i);
         return image_mem[sel * IMG_BYTES + i % IMG_BYTES];
      endfunction

      // top-left placement, clipped at the last column and page
      function void copy_aligned(int sel);
         int w, h, x0, y0, ex, ey;
         w  = width;
         h  = height;
         x0 = pos_x;
         y0 = pos_page;
         ex = x0 + w - 1;
         ey = y0 + h - 1;
         if (x0 + w > COLS) ex = COLS - 1;
         if (y0 + h > PAGES) ey = PAGES - 1;
         for (int y = y0; y <= ey; y++)
            for (int x = x0; x <= ex; x++)
               frame_mem[y * COLS + x] = image_byte(sel, (y - y0) * w + x - x0);
      endfunction

      // right/bottom placement; each byte straddles two image rows by the
      // bit shift, and pages past the last one are skipped
      function void place_scrolled(int sel);
         int w, h, px, b, s, ys, ye, xs, xe, k, c;
         bit [15:0] wide;
         bit [7:0] lo, hi;
         w  = width;
         h  = height;
         px = pos_x;
         b  = pos_bit_y >> 3;
         s  = pos_bit_y & 7;
         ys = (b - h < 0) ? 0 : b - h;
         ye = (b > PAGES - 1) ? PAGES - 1 : b;
         xs = (px - w < 0) ? 0 : px - w;
         xe = (px > COLS) ? COLS : px;
         for (int y = ys; y <= ye; y++) begin
            k = y - b + h;
            for (int x = xs; x < xe; x++) begin
               c  = x + w - px;
               lo = '0;
               hi = '0;
               if (k < h || k == 0) begin
                  wide = image_byte(sel, k * w + c);
                  wide = wide << s;
                  lo   = wide[7:0];
               end
               if (k > 0 && s != 0) hi = image_byte(sel, (k - 1) * w + c) >> (8 - s);
               frame_mem[y * COLS + x] = (k == 0) ? lo : (k < h) ? (lo | hi) : hi;
            end
         end
      endfunction

      function void take_word(func_type f, bit [1:0] sel, bit [9:0] idx,
                              bit [2:0] pg, bit [6:0] col, bit [7:0] dat);
         bit [7:0] result;
         result = '0;
         case (f)
            FUNC_LOAD:  image_mem[{sel, idx}] = dat;
            FUNC_BLIT:  if (scroll_mode) place_scrolled(sel); else copy_aligned(sel);
            FUNC_READ:  result = frame_mem[{pg, col}];
            FUNC_CLEAR: foreach (frame_mem[i]) frame_mem[i] = '0;
            default: ;
         endcase
         bytes_due.push_back(result);
      endfunction

      function void match_byte(logic [7:0] got);
         bit [7:0] want;
         if (bytes_due.size() == 0) begin
            errors++;
            $display("%0t: read_data expected none, got %02h", $time, got);
            return;
         end
         want = bytes_due.pop_front();
         compared++;
         if (got !== want) begin
            errors++;
            $display("%0t: read_data expected %02h, got %02h", $time, want, got);
         end
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic [FUNC_W-1:0]     req_func;
   logic [SEL_W-1:0]      req_image_select;
   logic [IDX_W-1:0]      req_image_index;
   logic [FPAGE_W-1:0]    req_frame_page;
   logic [FCOL_W-1:0]     req_frame_column;
   logic [DATA_W-1:0]     req_data_byte;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic [DATA_W-1:0]     rsp_read_data;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   frame_shadow shadow = new();
   bit          img_loaded [0:NUM_IMAGES_DEF*IMG_BYTES-1];
   bit          quiet;
   bit          calm;
   int          ready_hold;
   int          idle_cycles;
   int          words_sent;
   int          settings_done;
   int          blits, reads, clears;

   bit [7:0] fixed_cfg [0:6][0:5] = '{
      '{0,   1, 1,   0,  0,   0},
      '{0, 128, 1,   0,  7,   0},
      '{0,   3, 8, 127,  0,   0},
      '{0,   5, 2, 255, 15,   0},
      '{1,   1, 8,   1,  0, 127},
      '{1, 128, 1, 200,  0,   8},
      '{1,  16, 3,  10,  0,  13}
   };

   page_framebuffer_sprite_blitter_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_func         (req_func),
      .req_image_select (req_image_select),
      .req_image_index  (req_image_index),
      .req_frame_page   (req_frame_page),
      .req_frame_column (req_frame_column),
      .req_data_byte    (req_data_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_read_data    (rsp_read_data),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always #10 clock = ~clock;

   // response side back-pressure in random bursts
   always @(posedge clock) begin
      if (ready_hold != 0) begin
         ready_hold <= ready_hold - 1;
      end else if (!quiet && !calm && $urandom_range(0, 5) == 0) begin
         rsp_ready  <= 1'b0;
         ready_hold <= $urandom_range(0, 5);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // response words
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) shadow.match_byte(rsp_read_data);
   end

   // hang detection: no word moved on any channel for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles == STALL_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
            $display("testbench NOT OK");
            $finish;
         end
      end
   end

   task automatic push_word(func_type f, bit [1:0] sel, bit [9:0] idx,
                            bit [2:0] pg, bit [6:0] col, bit [7:0] dat);
      if (!quiet && !calm && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_func         <= f;
      req_image_select <= sel;
      req_image_index  <= idx;
      req_frame_page   <= pg;
      req_frame_column <= col;
      req_data_byte    <= dat;
      do @(posedge clock); while (!req_ready);
      shadow.take_word(f, sel, idx, pg, col, dat);
      if (f == FUNC_LOAD) img_loaded[{sel, idx}] = 1'b1;
      if (f == FUNC_BLIT) blits++;
      if (f == FUNC_READ) reads++;
      if (f == FUNC_CLEAR) clears++;
      words_sent++;
      if (words_sent >= TOTAL_WORDS * 85 / 100) quiet = 1'b1;
   endtask

   // wait for every outstanding response, request channel held idle
   task automatic settle();
      req_valid <= 1'b0;
      while (shadow.bytes_due.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type r, bit [7:0] d);
      csr_valid <= 1'b1;
      csr_index <= r;
      csr_data  <= d;
      do @(posedge clock); while (!csr_ready);
      shadow.set_reg(r, d);
   endtask

   task automatic apply_setting(bit m, bit [7:0] w, bit [3:0] h, bit [7:0] x,
                                bit [3:0] pg, bit [6:0] by);
      settle();
      write_reg(CSR_BLIT_MODE, m);
      write_reg(CSR_IMG_WIDTH, w);
      write_reg(CSR_IMG_HEIGHT, h);
      write_reg(CSR_POS_X, x);
      write_reg(CSR_POS_PAGE, pg);
      write_reg(CSR_POS_BIT_Y, by);
      csr_valid <= 1'b0;
      settings_done++;
   endtask

   // image bytes a blit may touch: one spare row covers the scroll tail
   function automatic int image_span();
      int span;
      span = (int'(shadow.height) + 1) * int'(shadow.width);
      return (span > IMG_BYTES) ? IMG_BYTES : span;
   endfunction

   // a blit must never see an image byte that was not loaded
   task automatic fill_image(bit [1:0] sel);
      int span;
      span = image_span();
      for (int i = 0; i < span; i++)
         if (!img_loaded[sel * IMG_BYTES + i])
            push_word(FUNC_LOAD, sel, i, $urandom, $urandom, $urandom);
   endtask

   task automatic random_word();
      int       pick;
      int       span;
      bit [1:0] sel;
      bit [2:0] pg;
      bit [6:0] col;
      pick = $urandom_range(0, 99);
      span = image_span();
      sel  = $urandom;
      if (pick < 35) begin
         if ($urandom_range(0, 1))
            push_word(FUNC_LOAD, sel, $urandom_range(0, (span + 15 > IMG_BYTES - 1) ?
                      IMG_BYTES - 1 : span + 15), $urandom, $urandom, $urandom);
         else
            push_word(FUNC_LOAD, sel, $urandom, $urandom, $urandom, $urandom);
      end else if (pick < 58) begin
         if (span > 64) sel = 0;
         fill_image(sel);
         push_word(FUNC_BLIT, sel, $urandom, $urandom, $urandom, $urandom);
      end else if (pick < 96) begin
         // aim half the reads at the area the current setting paints
         if ($urandom_range(0, 1)) begin
            if (shadow.scroll_mode) begin
               pg  = (shadow.pos_bit_y >> 3) - $urandom_range(0, shadow.height);
               col = shadow.pos_x - 1 - $urandom_range(0, shadow.width);
            end else begin
               pg  = shadow.pos_page + $urandom_range(0, shadow.height);
               col = shadow.pos_x + $urandom_range(0, shadow.width);
            end
         end else begin
            pg  = $urandom;
            col = $urandom;
         end
         push_word(FUNC_READ, sel, $urandom, pg, col, $urandom);
      end else begin
         push_word(FUNC_CLEAR, sel, $urandom, $urandom, $urandom, $urandom);
      end
   endtask

   initial begin
      int phase_no;
      int n;
      bit m;
      bit [7:0] w, x;
      bit [3:0] h, pg;
      bit [6:0] by;

      clock            = 1'b0;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_func         = FUNC_LOAD;
      req_image_select = '0;
      req_image_index  = '0;
      req_frame_page   = '0;
      req_frame_column = '0;
      req_data_byte    = '0;
      rsp_ready        = 1'b1;
      csr_valid        = 1'b0;
      csr_index        = CSR_BLIT_MODE;
      csr_data         = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // frame must read as zero once the power-up clear is done
      push_word(FUNC_READ, 0, 0, 0, 0, 0);
      push_word(FUNC_READ, 3, 1023, 7, 127, 8'hFF);

      // two-column image into the bottom-right corner
      apply_setting(0, 2, 1, 126, 7, 0);
      push_word(FUNC_LOAD, 3, 0, 0, 0, 8'h00);
      push_word(FUNC_LOAD, 3, 1, 7, 127, 8'hFF);
      push_word(FUNC_LOAD, 3, 2, 0, 0, 8'hA5);
      push_word(FUNC_LOAD, 3, 3, 0, 0, 8'h5A);
      push_word(FUNC_LOAD, 0, 1023, 0, 0, 8'hFF);
      push_word(FUNC_BLIT, 3, 0, 0, 0, 0);
      push_word(FUNC_READ, 0, 0, 7, 126, 0);
      push_word(FUNC_READ, 0, 0, 7, 127, 0);

      // same image shifted down by four bits across pages 0 and 1
      apply_setting(1, 2, 1, 2, 0, 12);
      push_word(FUNC_BLIT, 3, 0, 0, 0, 0);
      push_word(FUNC_READ, 0, 0, 0, 0, 0);
      push_word(FUNC_READ, 0, 0, 0, 1, 0);
      push_word(FUNC_READ, 0, 0, 1, 0, 0);
      push_word(FUNC_READ, 0, 0, 1, 1, 0);
      push_word(FUNC_CLEAR, 0, 0, 0, 0, 0);
      push_word(FUNC_READ, 0, 0, 7, 127, 0);
      push_word(FUNC_READ, 0, 0, 1, 0, 0);

      // random phases, the corner settings first
      phase_no = 0;
      while (words_sent < TOTAL_WORDS) begin
         if (phase_no < 7) begin
            m  = fixed_cfg[phase_no][0];
            w  = fixed_cfg[phase_no][1];
            h  = fixed_cfg[phase_no][2];
            x  = fixed_cfg[phase_no][3];
            pg = fixed_cfg[phase_no][4];
            by = fixed_cfg[phase_no][5];
         end else begin
            m = $urandom_range(0, 1);
            if ($urandom_range(0, 4) == 0) begin
               w = $urandom_range(21, 128);
               h = 1;
            end else begin
               w = $urandom_range(1, 20);
               h = (w <= 8 && $urandom_range(0, 5) == 0) ? 8 : $urandom_range(1, 4);
            end
            x  = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 140);
            pg = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 7);
            by = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 71);
         end
         apply_setting(m, w, h, x, pg, by);
         calm = ($urandom_range(0, 3) == 0);
         n = $urandom_range(12, 40);
         for (int i = 0; i < n && words_sent < TOTAL_WORDS; i++) random_word();
         phase_no++;
      end

      settle();
      repeat (40) @(posedge clock);
      if (shadow.bytes_due.size() != 0) begin
         shadow.errors++;
         $display("%0t: %0d read bytes never returned", $time, shadow.bytes_due.size());
      end
      $display("%0d request words under %0d register settings: %0d blits, %0d reads, %0d clears",
               words_sent, settings_done, blits, reads, clears);
      $display("%0d response bytes compared, %0d errors", shadow.compared, shadow.errors);
      if (shadow.errors == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

endmodule
